// ----- rtl/assert_macros.svh -----
// Assertion macros used by the transcoder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define UCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define UCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/uct_pkg.sv -----
// Shared types and constants of the Unicode character transcoder.
package uct_pkg;

    localparam int CHAR_W  = 32;
    localparam int COUNT_W = 3;
    localparam int ENC_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // Encoding codes; the unused code falls back to UTF-32.
    localparam logic [ENC_W-1:0] ENC_UTF8  = 2'd0;
    localparam logic [ENC_W-1:0] ENC_UTF16 = 2'd1;
    localparam logic [ENC_W-1:0] ENC_UTF32 = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ENCODING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ENCODING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BIG_ENDIAN = 2'd2;

    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [31:0] SUPP_BASE      = 32'h0001_0000;
    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

    localparam logic [COUNT_W-1:0] COUNT_1 = 3'd1;
    localparam logic [COUNT_W-1:0] COUNT_2 = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_3 = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_4 = 3'd4;

    typedef struct packed {
        logic [CHAR_W-1:0]  encoded_char;
        logic [COUNT_W-1:0] byte_count;
        logic               out_of_range;
    } t_enc_result;

endpackage

// ----- rtl/uct_stream_if.sv -----
// Valid/ready channel interfaces for source characters and encoded results.
interface uct_in_if import uct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] packed_char;

    modport source (output valid, output packed_char, input ready);
    modport sink (input valid, input packed_char, output ready);
endinterface

interface uct_out_if import uct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  encoded_char;
    logic [COUNT_W-1:0] byte_count;
    logic               out_of_range;

    modport source (output valid, output encoded_char, output byte_count,
                    output out_of_range, input ready);
    modport sink (input valid, input encoded_char, input byte_count,
                  input out_of_range, output ready);
endinterface

// ----- rtl/uct_decode.sv -----
// Source decoder: packed UTF-8, UTF-16 or UTF-32 character to a 32-bit value.
module uct_decode import uct_pkg::*; (
    input  logic [CHAR_W-1:0] i_packed_char,
    input  logic [ENC_W-1:0]  i_source_encoding,
    output logic [CHAR_W-1:0] o_code_point
);

    logic [7:0]  w_b0;
    logic [5:0]  w_b1;
    logic [5:0]  w_b2;
    logic [5:0]  w_b3;
    logic [15:0] w_lo;
    logic [15:0] w_hi;
    logic [CHAR_W-1:0] w_utf8_cp;
    logic [CHAR_W-1:0] w_utf16_cp;

    assign w_b0 = i_packed_char[7:0];
    assign w_b1 = i_packed_char[13:8];
    assign w_b2 = i_packed_char[21:16];
    assign w_b3 = i_packed_char[29:24];
    assign w_lo = i_packed_char[15:0];
    assign w_hi = i_packed_char[31:16];

    // Length comes from the lead byte; continuation bytes give their low six bits.
    always_comb begin
        if (!w_b0[7]) begin
            w_utf8_cp = {24'd0, w_b0};
        end else if (w_b0[7:5] == 3'b110) begin
            w_utf8_cp = {21'd0, w_b0[4:0], w_b1};
        end else if (w_b0[7:4] == 4'b1110) begin
            w_utf8_cp = {16'd0, w_b0[3:0], w_b1, w_b2};
        end else if (w_b0[7:3] == 5'b11110) begin
            w_utf8_cp = {11'd0, w_b0[2:0], w_b1, w_b2, w_b3};
        end else begin
            w_utf8_cp = {24'd0, w_b0};
        end
    end

    // A nonzero high unit marks a pair; malformed pairs wrap modulo 2^32.
    always_comb begin
        if (w_hi == 16'd0) begin
            w_utf16_cp = {16'd0, w_lo};
        end else begin
            w_utf16_cp = SUPP_BASE
                       + ({6'd0, w_lo, 10'd0} - {6'd0, SURR_HIGH_BASE, 10'd0})
                       + ({16'd0, w_hi} - {16'd0, SURR_LOW_BASE});
        end
    end

    always_comb begin
        unique case (i_source_encoding)
            ENC_UTF8:  o_code_point = w_utf8_cp;
            ENC_UTF16: o_code_point = w_utf16_cp;
            default:   o_code_point = i_packed_char;
        endcase
    end

endmodule

// ----- rtl/uct_encode.sv -----
// Target encoder: code point to packed UTF-8, UTF-16 or UTF-32, little-endian order.
module uct_encode import uct_pkg::*; (
    input  logic [CHAR_W-1:0] i_code_point,
    input  logic [ENC_W-1:0]  i_target_encoding,
    output t_enc_result       o_result
);

    logic [20:0] w_c;
    logic [20:0] w_d;
    logic [15:0] w_hs;
    logic [15:0] w_ls;
    logic        w_oor;
    logic [CHAR_W-1:0]  w_utf8;
    logic [COUNT_W-1:0] w_utf8_n;

    assign w_oor = i_code_point > MAX_CODE_POINT;
    assign w_c   = i_code_point[20:0];
    assign w_d   = w_c - SUPP_BASE[20:0];
    assign w_hs  = SURR_HIGH_BASE + {5'd0, w_d[20:10]};
    assign w_ls  = SURR_LOW_BASE + {6'd0, w_d[9:0]};

    always_comb begin
        if (w_c[20:7] == 14'd0) begin
            w_utf8   = {25'd0, w_c[6:0]};
            w_utf8_n = COUNT_1;
        end else if (w_c[20:11] == 10'd0) begin
            w_utf8   = {16'd0, 2'b10, w_c[5:0], 3'b110, w_c[10:6]};
            w_utf8_n = COUNT_2;
        end else if (w_c[20:16] == 5'd0) begin
            w_utf8   = {8'd0, 2'b10, w_c[5:0], 2'b10, w_c[11:6], 4'b1110, w_c[15:12]};
            w_utf8_n = COUNT_3;
        end else begin
            w_utf8   = {2'b10, w_c[5:0], 2'b10, w_c[11:6], 2'b10, w_c[17:12],
                        5'b11110, w_c[20:18]};
            w_utf8_n = COUNT_4;
        end
    end

    always_comb begin
        o_result.out_of_range = w_oor;
        unique case (i_target_encoding)
            ENC_UTF8: begin
                o_result.encoded_char = w_utf8;
                o_result.byte_count   = w_utf8_n;
            end
            ENC_UTF16: begin
                if (w_c[20:16] == 5'd0) begin
                    o_result.encoded_char = {16'd0, w_c[15:0]};
                    o_result.byte_count   = COUNT_2;
                end else begin
                    o_result.encoded_char = {w_ls, w_hs};
                    o_result.byte_count   = COUNT_4;
                end
            end
            default: begin
                o_result.encoded_char = {11'd0, w_c};
                o_result.byte_count   = COUNT_4;
            end
        endcase
    end

endmodule

// ----- rtl/unicode_char_transcoder_core.sv -----
// Top level of the Unicode character transcoder: config registers and 3-stage pipeline.
// Path from input request to result request: decode, encode, byte order, each registered.
// Throughput: one character per cycle while the output takes results; each stage holds
// one item and refills as soon as the stage behind it moves, so bubbles collapse under a stalled output.
// Reset (synchronous, active low): empty all stages, source UTF-8, target UTF-16,
// little-endian output.
module unicode_char_transcoder_core import uct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    uct_in_if.sink                i_char,
    uct_out_if.source             o_char,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers; the user must write them only while the pipeline is empty (not enforced here).
    logic [ENC_W-1:0] r_source_encoding;
    logic [ENC_W-1:0] r_target_encoding;
    logic             r_target_big_endian;

    // Stage 1 holds the decoded value, stage 2 the encoded result,
    // stage 3 the byte-ordered result that drives the output.
    logic              r_s1_valid;
    logic [CHAR_W-1:0] r_s1_cp;
    logic              r_s2_valid;
    t_enc_result       r_s2_res;
    logic              r_s3_valid;
    t_enc_result       r_s3_res;

    logic              w_s1_ready;
    logic              w_s2_ready;
    logic              w_s3_ready;
    logic [CHAR_W-1:0] w_code_point;
    t_enc_result       w_enc_res;
    t_enc_result       n_s3_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_encoding   <= ENC_UTF8;
            r_target_encoding   <= ENC_UTF16;
            r_target_big_endian <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_ENCODING:   r_source_encoding   <= i_cfg_data[ENC_W-1:0];
                CFG_TARGET_ENCODING:   r_target_encoding   <= i_cfg_data[ENC_W-1:0];
                CFG_TARGET_BIG_ENDIAN: r_target_big_endian <= i_cfg_data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // A stage takes a new item when it is empty or its item moves on this cycle.
    assign w_s3_ready  = !r_s3_valid || o_char.ready;
    assign w_s2_ready  = !r_s2_valid || w_s3_ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign i_char.ready = w_s1_ready;

    // Stage 1: decode the source character.
    uct_decode u_decode (
        .i_packed_char    (i_char.packed_char),
        .i_source_encoding(r_source_encoding),
        .o_code_point     (w_code_point)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_char.valid) begin
            r_s1_cp <= w_code_point;
        end
    end

    // Stage 2: range check and re-encode from the low 21 bits.
    uct_encode u_encode (
        .i_code_point     (r_s1_cp),
        .i_target_encoding(r_target_encoding),
        .o_result         (w_enc_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_s2_res <= w_enc_res;
        end
    end

    // Stage 3: big-endian order swaps bytes within each UTF-16 unit, or
    // reverses the whole word for UTF-32. UTF-8 has no unit order.
    always_comb begin
        n_s3_res = r_s2_res;
        if (r_target_big_endian) begin
            case (r_target_encoding)
                ENC_UTF8: ;
                ENC_UTF16: begin
                    n_s3_res.encoded_char = {r_s2_res.encoded_char[23:16],
                                             r_s2_res.encoded_char[31:24],
                                             r_s2_res.encoded_char[7:0],
                                             r_s2_res.encoded_char[15:8]};
                end
                default: begin
                    n_s3_res.encoded_char = {r_s2_res.encoded_char[7:0],
                                             r_s2_res.encoded_char[15:8],
                                             r_s2_res.encoded_char[23:16],
                                             r_s2_res.encoded_char[31:24]};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    // Hold the result while the output request is stalled.
    always_ff @(posedge i_clk) begin
        if (w_s3_ready && r_s2_valid) begin
            r_s3_res <= n_s3_res;
        end
    end

    assign o_char.valid        = r_s3_valid;
    assign o_char.encoded_char = r_s3_res.encoded_char;
    assign o_char.byte_count   = r_s3_res.byte_count;
    assign o_char.out_of_range = r_s3_res.out_of_range;

endmodule

// ----- rtl/uct_checker.sv -----
// Port-level checker for the transcoder core and its bind.
`include "assert_macros.svh"

module uct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_encoded_char,
    input logic [2:0]  i_byte_count,
    input logic        i_out_of_range
);

    `UCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_encoded_char) && $stable(i_byte_count) && $stable(i_out_of_range), "stalled result changed")

    `UCT_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, i_out_valid, i_byte_count != 3'd0 && i_byte_count <= 3'd4, "byte count outside one to four")

    `UCT_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input refused with empty output stage")

    `UCT_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready, i_out_valid, "accepted character missing after three cycles")

endmodule

bind unicode_char_transcoder_core uct_checker u_uct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_char.valid),
    .i_in_ready    (i_char.ready),
    .i_out_valid   (o_char.valid),
    .i_out_ready   (o_char.ready),
    .i_encoded_char(o_char.encoded_char),
    .i_byte_count  (o_char.byte_count),
    .i_out_of_range(o_char.out_of_range)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the Unicode character transcoder core.
`timescale 1ns / 100ps

module testbench;
    import uct_pkg::*;

    // Encoding code 3 is not named in the package; the core folds it into UTF-32.
    localparam logic [ENC_W-1:0]     ENC_CODE_SPARE  = 2'd3;
    // Index 3 is no register at all; writes to it must leave the setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int                   HOLD_OFF_CYCLES = 64;
    localparam int                   ITEMS_PER_BLOCK = 83;
    localparam int                   MAX_REPORTED    = 10;

    // One row of the directed table: register setting, source character and,
    // where it is plain to see, the expected result typed in by hand.
    typedef struct packed {
        logic [ENC_W-1:0] src;
        logic [ENC_W-1:0] tgt;
        logic             be;
        logic [31:0]      ch;
        logic             typed;
        t_enc_result      want;
    } t_row;

    // Hand-typed answer, queued per offered request and taken at acceptance.
    typedef struct packed {
        logic        typed;
        t_enc_result want;
    } t_known_answer;

    typedef struct packed {
        logic [31:0] source_char;
        t_enc_result want;
    } t_expected_char;

    localparam t_enc_result NO_ANSWER = '0;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    uct_in_if  char_in ();
    uct_out_if char_out ();

    unicode_char_transcoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (char_in),
        .o_char     (char_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the register file, updated from the write port as the core sees it.
    logic [ENC_W-1:0] cur_src = ENC_UTF8;
    logic [ENC_W-1:0] cur_tgt = ENC_UTF16;
    logic             cur_be  = 1'b0;

    t_known_answer  known_answers[$];
    t_expected_char pending_chars[$];

    int fail_count       = 0;
    int chars_accepted   = 0;
    int results_checked  = 0;
    int oor_seen         = 0;
    int settings_applied = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int hold_requests    = 0;
    int holds_served     = 0;
    int hold_left        = 0;

    // Directed table: reset setting first, then a selection of other source/target
    // pairings, big-endian output, the spare encoding code and the out-of-range paths.
    t_row directed_rows [25] = '{
        // Reset setting: UTF-8 in, UTF-16 little-endian out.
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'h0000_0041, 1'b1, '{32'h0000_0041, COUNT_2, 1'b0}},
        // ASCII lead: garbage in the unused upper bytes is dropped.
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'hFFFF_FF7F, 1'b1, '{32'h0000_007F, COUNT_2, 1'b0}},
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'h0000_0000, 1'b1, '{32'h0000_0000, COUNT_2, 1'b0}},
        // Invalid lead byte stands for itself.
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'h0000_00FF, 1'b1, '{32'h0000_00FF, COUNT_2, 1'b0}},
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'h0000_0080, 1'b0, NO_ANSWER},
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'h0000_A9C2, 1'b0, NO_ANSWER},
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'h00AC_82E2, 1'b0, NO_ANSWER},
        // First supplementary code point becomes a surrogate pair.
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'h8080_90F0, 1'b1, '{32'hDC00_D800, COUNT_4, 1'b0}},
        // Largest 4-byte lead with full continuations: out of range.
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'hBFBF_BFF7, 1'b0, NO_ANSWER},
        '{ENC_UTF8,  ENC_UTF16, 1'b0, 32'hFFFF_FFF8, 1'b0, NO_ANSWER},
        // UTF-16 in, UTF-8 out.
        '{ENC_UTF16, ENC_UTF8,  1'b0, 32'h0000_FFFF, 1'b0, NO_ANSWER},
        '{ENC_UTF16, ENC_UTF8,  1'b0, 32'hDC00_D800, 1'b1, '{32'h8080_90F0, COUNT_4, 1'b0}},
        // Lone surrogate goes out as a plain 3-byte sequence.
        '{ENC_UTF16, ENC_UTF8,  1'b0, 32'h0000_D800, 1'b0, NO_ANSWER},
        // Malformed pairs: arithmetic wraps and may leave the code space.
        '{ENC_UTF16, ENC_UTF8,  1'b0, 32'hFFFF_FFFF, 1'b0, NO_ANSWER},
        '{ENC_UTF16, ENC_UTF8,  1'b0, 32'h0001_0000, 1'b0, NO_ANSWER},
        '{ENC_UTF16, ENC_UTF8,  1'b0, 32'h0000_0000, 1'b1, '{32'h0000_0000, COUNT_1, 1'b0}},
        '{ENC_UTF16, ENC_UTF8,  1'b0, 32'h0000_0080, 1'b0, NO_ANSWER},
        // UTF-32 both ways, big-endian: all four bytes reversed.
        '{ENC_UTF32, ENC_UTF32, 1'b1, 32'h0010_FFFF, 1'b1, '{32'hFFFF_1000, COUNT_4, 1'b0}},
        '{ENC_UTF32, ENC_UTF32, 1'b1, 32'hFFFF_FFFF, 1'b0, NO_ANSWER},
        '{ENC_UTF32, ENC_UTF32, 1'b1, 32'h0011_0000, 1'b0, NO_ANSWER},
        // Spare code on both sides falls back to UTF-32.
        '{ENC_CODE_SPARE, ENC_CODE_SPARE, 1'b0, 32'h1234_5678, 1'b0, NO_ANSWER},
        // Big-endian UTF-16: bytes swap inside each unit.
        '{ENC_UTF32, ENC_UTF16, 1'b1, 32'h0000_0041, 1'b1, '{32'h0000_4100, COUNT_2, 1'b0}},
        '{ENC_UTF32, ENC_UTF16, 1'b1, 32'h0001_F600, 1'b0, NO_ANSWER},
        // Big-endian flag has no effect on UTF-8 output.
        '{ENC_UTF32, ENC_UTF8,  1'b1, 32'h0000_07FF, 1'b0, NO_ANSWER},
        '{ENC_UTF32, ENC_UTF8,  1'b1, 32'h0000_0800, 1'b0, NO_ANSWER}
    };

    // Clock: 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Decode one source character to a code point and re-encode it.
    function automatic t_enc_result transcode_char(input logic [31:0] ch,
                                                   input logic [ENC_W-1:0] src,
                                                   input logic [ENC_W-1:0] tgt,
                                                   input logic be);
        logic [31:0] cp;
        logic [31:0] code;
        logic [31:0] enc;
        logic [31:0] offs;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [5:0]  c1;
        logic [5:0]  c2;
        logic [5:0]  c3;
        t_enc_result res;
        c1 = ch[13:8];
        c2 = ch[21:16];
        c3 = ch[29:24];
        lo = ch[15:0];
        hi = ch[31:16];
        case (src)
            ENC_UTF8: begin
                // Length comes from the lead byte alone; continuations give 6 bits each.
                if (!ch[7])
                    cp = {24'h0, ch[7:0]};
                else if (ch[7:5] == 3'b110)
                    cp = {21'h0, ch[4:0], c1};
                else if (ch[7:4] == 4'b1110)
                    cp = {16'h0, ch[3:0], c1, c2};
                else if (ch[7:3] == 5'b11110)
                    cp = {11'h0, ch[2:0], c1, c2, c3};
                else
                    cp = {24'h0, ch[7:0]};
            end
            ENC_UTF16: begin
                // Any nonzero high unit means a pair, checked or not; wrap at 32 bits.
                if (hi == 16'h0)
                    cp = {16'h0, lo};
                else
                    cp = SUPP_BASE + ({16'h0, lo} - {16'h0, SURR_HIGH_BASE}) * 32'h400
                         + ({16'h0, hi} - {16'h0, SURR_LOW_BASE});
            end
            default: cp = ch;
        endcase
        res.out_of_range = (cp > MAX_CODE_POINT);
        code = {11'h0, cp[20:0]};
        case (tgt)
            ENC_UTF8: begin
                if (code < 32'h80) begin
                    enc = code;
                    res.byte_count = COUNT_1;
                end else if (code < 32'h800) begin
                    enc = {16'h0, 2'b10, code[5:0], 3'b110, code[10:6]};
                    res.byte_count = COUNT_2;
                end else if (code < SUPP_BASE) begin
                    enc = {8'h0, 2'b10, code[5:0], 2'b10, code[11:6], 4'b1110, code[15:12]};
                    res.byte_count = COUNT_3;
                end else begin
                    enc = {2'b10, code[5:0], 2'b10, code[11:6], 2'b10, code[17:12],
                           5'b11110, code[20:18]};
                    res.byte_count = COUNT_4;
                end
            end
            ENC_UTF16: begin
                if (code < SUPP_BASE) begin
                    enc = code;
                    res.byte_count = COUNT_2;
                end else begin
                    offs = code - SUPP_BASE;
                    enc[15:0]  = offs[25:10] + SURR_HIGH_BASE;
                    enc[31:16] = {6'h0, offs[9:0]} + SURR_LOW_BASE;
                    res.byte_count = COUNT_4;
                end
                if (be)
                    enc = {enc[23:16], enc[31:24], enc[7:0], enc[15:8]};
            end
            default: begin
                enc = code;
                res.byte_count = COUNT_4;
                if (be)
                    enc = {enc[7:0], enc[15:8], enc[23:16], enc[31:24]};
            end
        endcase
        res.encoded_char = enc;
        return res;
    endfunction

    // Build a random source character: mostly well-formed, some broken, some noise.
    function automatic logic [31:0] random_char(input logic [ENC_W-1:0] src);
        logic [31:0] junk;
        logic [31:0] r;
        int unsigned kind;
        logic [31:0] ch;
        junk = $urandom;
        r    = $urandom;
        kind = $urandom_range(0, 9);
        case (src)
            ENC_UTF8: begin
                case (kind)
                    0, 1:    ch = {junk[31:8], 1'b0, r[6:0]};
                    2, 3:    ch = {junk[31:16], 2'b10, r[5:0], 3'b110, r[10:6]};
                    4, 5:    ch = {junk[31:24], 2'b10, r[5:0], 2'b10, r[11:6],
                                   4'b1110, r[15:12]};
                    6, 7:    ch = {2'b10, r[5:0], 2'b10, r[11:6], 2'b10, r[17:12],
                                   5'b11110, r[20:18]};
                    8:       ch = {junk[31:8], r[31] ? {2'b10, r[5:0]} : {5'b11111, r[2:0]}};
                    default: ch = junk;
                endcase
            end
            ENC_UTF16: begin
                case (kind)
                    0, 1, 2, 3:    ch = {16'h0, r[15:0]};
                    4, 5, 6, 7:    ch = {6'b110111, r[9:0], 6'b110110, r[19:10]};
                    8:             ch = {16'h0, 5'b11011, r[10:0]};
                    default:       ch = junk;
                endcase
            end
            default: begin
                case (kind)
                    0, 1, 2, 3, 4, 5: ch = $urandom_range(0, MAX_CODE_POINT);
                    6:                ch = {11'h0, r[20:0]};
                    7:                ch = $urandom_range(0, 32'h7FF);
                    default:          ch = junk;
                endcase
            end
        endcase
        return ch;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("[%0t] error: %s", $realtime, msg);
    endtask

    // Offer one request and hold it until the core takes it.
    task automatic send_char(input logic [31:0] value, input logic typed,
                             input t_enc_result want);
        known_answers.push_back('{typed, want});
        while ($urandom_range(0, 99) < send_idle_pct) begin
            char_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_in.valid       <= 1'b1;
        char_in.packed_char <= value;
        do @(posedge i_clk); while (!char_in.ready);
    endtask

    // Drain the pipeline, then write all three registers back to back, and the spare index when asked.
    task automatic apply_setting(input logic [ENC_W-1:0] src, input logic [ENC_W-1:0] tgt,
                                 input logic be, input logic touch_spare);
        char_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0 || known_answers.size() != 0)
            @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SOURCE_ENCODING;
        i_cfg_data <= src;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TARGET_ENCODING;
        i_cfg_data <= tgt;
        @(posedge i_clk);
        // Upper data bit is don't-care for the one-bit register; drive it randomly anyway.
        i_cfg_idx  <= CFG_TARGET_BIG_ENDIAN;
        i_cfg_data <= {1'($urandom), be};
        @(posedge i_clk);
        if (touch_spare) begin
            i_cfg_idx  <= CFG_SPARE_INDEX;
            i_cfg_data <= 2'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Receiver: random back-pressure, plus long hold-offs on request so the
    // pipeline fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_out.ready <= 1'b0;
        end else if (hold_left != 0) begin
            char_out.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            char_out.ready <= 1'b0;
            hold_left      <= HOLD_OFF_CYCLES - 1;
            holds_served   <= holds_served + 1;
        end else begin
            char_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: track register writes, predict each accepted request, and
    // check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_known_answer  ans;
        t_expected_char exp_item;
        t_enc_result    got;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SOURCE_ENCODING:   cur_src = i_cfg_data;
                    CFG_TARGET_ENCODING:   cur_tgt = i_cfg_data;
                    CFG_TARGET_BIG_ENDIAN: cur_be  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (char_in.valid && char_in.ready) begin
                ans = known_answers.pop_front();
                exp_item.source_char = char_in.packed_char;
                exp_item.want = ans.typed ? ans.want
                              : transcode_char(char_in.packed_char, cur_src, cur_tgt, cur_be);
                pending_chars.push_back(exp_item);
                chars_accepted++;
            end
            if (char_out.valid && char_out.ready) begin
                got.encoded_char = char_out.encoded_char;
                got.byte_count   = char_out.byte_count;
                got.out_of_range = char_out.out_of_range;
                if (pending_chars.size() == 0) begin
                    note_failure($sformatf("result %h/%0d/%0b with nothing pending",
                                           got.encoded_char, got.byte_count,
                                           got.out_of_range));
                end else begin
                    exp_item = pending_chars.pop_front();
                    results_checked++;
                    if (got.out_of_range === 1'b1)
                        oor_seen++;
                    if (got.encoded_char !== exp_item.want.encoded_char ||
                        got.byte_count !== exp_item.want.byte_count ||
                        got.out_of_range !== exp_item.want.out_of_range)
                        note_failure($sformatf(
                            "char %h: expected %h/%0d/%0b, got %h/%0d/%0b",
                            exp_item.source_char, exp_item.want.encoded_char,
                            exp_item.want.byte_count, exp_item.want.out_of_range,
                            got.encoded_char, got.byte_count, got.out_of_range));
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random blocks under three idling mixes.
    initial begin
        logic [ENC_W-1:0] row_src;
        logic [ENC_W-1:0] row_tgt;
        logic             row_be;
        logic [ENC_W-1:0] blk_src;
        int               k;
        i_rst_n             = 1'b0;
        char_in.valid       = 1'b0;
        char_in.packed_char = '0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_SOURCE_ENCODING;
        i_cfg_data          = '0;
        row_src             = ENC_UTF8;
        row_tgt             = ENC_UTF16;
        row_be              = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run under the first idling mix.
        send_idle_pct = 27;
        recv_idle_pct = 78;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].src != row_src || directed_rows[i].tgt != row_tgt ||
                directed_rows[i].be != row_be) begin
                row_src = directed_rows[i].src;
                row_tgt = directed_rows[i].tgt;
                row_be  = directed_rows[i].be;
                apply_setting(row_src, row_tgt, row_be, settings_applied == 0);
            end
            send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random part: sweep source and target codes across the blocks, every pairing but spare to spare.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 27; recv_idle_pct = 78; end
                1:       begin send_idle_pct = 78; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int blk = 0; blk < 5; blk++) begin
                k       = phase * 5 + blk;
                blk_src = k[1:0];
                apply_setting(blk_src, k[3:2], 1'($urandom), $urandom_range(0, 3) == 0);
                // Stall the receiver at the start of each mix while requests keep coming.
                if (blk == 0)
                    hold_requests <= hold_requests + 1;
                repeat (ITEMS_PER_BLOCK)
                    send_char(random_char(blk_src), 1'b0, NO_ANSWER);
            end
        end
        char_in.valid <= 1'b0;

        // Drain, then wait on so the pipeline can show stray results.
        while (pending_chars.size() != 0 || known_answers.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_chars.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_chars.size()));

        $display("covered %0d characters over %0d register settings, %0d results checked",
                 chars_accepted, settings_applied, results_checked);
        $display("%0d out-of-range results, %0d receiver hold-offs, %0d failures",
                 oor_seen, hold_requests, fail_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout with %0d results still pending", pending_chars.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
